// ----- rtl/bmpc_pkg.sv -----
// Package for the bitmap tricolour pixel classifier.
// Holds sizes, codes, shared structs and the pixel classification functions.
// No dependencies.
package bmpc_pkg;

    localparam int MAX_ROW_PIXELS  = 1024;
    localparam int PALETTE_ENTRIES = 256;

    localparam int COL_W     = $clog2(MAX_ROW_PIXELS + 1);
    localparam int PAL_AW    = $clog2(PALETTE_ENTRIES);
    localparam int ROW_W     = 11;
    localparam int OUT_COL_W = 10;
    localparam int DEPTH_W   = 5;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [DEPTH_W-1:0] DEPTH_1  = 5'd1;
    localparam logic [DEPTH_W-1:0] DEPTH_4  = 5'd4;
    localparam logic [DEPTH_W-1:0] DEPTH_8  = 5'd8;
    localparam logic [DEPTH_W-1:0] DEPTH_16 = 5'd16;
    localparam logic [DEPTH_W-1:0] DEPTH_24 = 5'd24;

    localparam logic OP_PALETTE = 1'b0;
    localparam logic OP_PIXEL   = 1'b1;

    localparam logic [1:0] COLOR_BLACK = 2'd0;
    localparam logic [1:0] COLOR_WHITE = 2'd1;
    localparam logic [1:0] COLOR_RED   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BIT_DEPTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_SIX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_EN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PIXELS = 2'd3;

    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;

    localparam logic [7:0] THR_WHITE = 8'h80;
    localparam logic [9:0] THR_SUM   = 10'd384;
    localparam logic [7:0] THR_COLOR = 8'hF0;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               green_six;
        logic               color_en;
        logic [ROW_W-1:0]   row_pixels;
    } t_cfg;

    typedef struct packed {
        logic                 pal;
        logic                 pn_ok;
        logic                 col_on;
        logic [1:0]           color;
        logic [OUT_COL_W-1:0] column;
        logic                 last;
    } t_pix;

    function automatic logic f_whitish(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b, input logic col);
        logic [9:0] sum;
        sum = {2'b00, r} + {2'b00, g} + {2'b00, b};
        if (col) begin
            return (r > THR_WHITE) && (g > THR_WHITE) && (b > THR_WHITE);
        end
        return sum > THR_SUM;
    endfunction

    function automatic logic f_colored(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
        return (r > THR_COLOR) || ((g > THR_COLOR) && (b > THR_COLOR));
    endfunction

    function automatic logic [1:0] f_pick(input logic wh, input logic co, input logic col);
        if (wh) begin
            return COLOR_WHITE;
        end
        if (co && col) begin
            return COLOR_RED;
        end
        return COLOR_BLACK;
    endfunction

endpackage

// ----- rtl/bmp_pixel_tricolor_classifier.sv -----
// Bitmap row byte to black/white/red pixel classifier: top level.
// Pixels are registered in the result stage, reaching the result port in the cycle
// after their byte steps. Throughput: one byte per cycle at depths 24, 16, 8 if not
// stalled; depths 4, 1 hold a byte to its last pixel; palette pixels read RAM once.
// Reset: config returns to depth 24, 555, colour off, zero row pixels; column
// and assembly clear; the palette RAM is not cleared and is undefined until written.
module bmp_pixel_tricolor_classifier
    import bmpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_operation,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_row_start,
    input  logic [7:0]           i_palette_index,
    input  logic [7:0]           i_palette_red,
    input  logic [7:0]           i_palette_green,
    input  logic [7:0]           i_palette_blue,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_pixel_color,
    output logic [OUT_COL_W-1:0] o_column,
    output logic                 o_last_of_run
);

    t_cfg              r_cfg;
    logic              pix_valid;
    logic              pix_ready;
    t_pix              pix;
    logic              ram_we;
    logic [PAL_AW-1:0] ram_waddr;
    logic [1:0]        ram_wdata;
    logic              ram_re;
    logic [PAL_AW-1:0] ram_raddr;
    logic [1:0]        ram_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.depth      <= DEPTH_24;
            r_cfg.green_six  <= 1'b0;
            r_cfg.color_en   <= 1'b0;
            r_cfg.row_pixels <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BIT_DEPTH:  r_cfg.depth      <= i_cfg_data[DEPTH_W-1:0];
                CFG_GREEN_SIX:  r_cfg.green_six  <= i_cfg_data[0];
                CFG_COLOR_EN:   r_cfg.color_en   <= i_cfg_data[0];
                CFG_ROW_PIXELS: r_cfg.row_pixels <= i_cfg_data[ROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bmpc_expand u_expand (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_data_byte     (i_data_byte),
        .i_row_start     (i_row_start),
        .i_palette_index (i_palette_index),
        .i_palette_red   (i_palette_red),
        .i_palette_green (i_palette_green),
        .i_palette_blue  (i_palette_blue),
        .o_pix_valid     (pix_valid),
        .i_pix_ready     (pix_ready),
        .o_pix           (pix),
        .o_ram_we        (ram_we),
        .o_ram_waddr     (ram_waddr),
        .o_ram_wdata     (ram_wdata),
        .o_ram_re        (ram_re),
        .o_ram_raddr     (ram_raddr)
    );

    bmpc_ram #(
        .WIDTH (2),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bmpc_result u_result (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix_valid   (pix_valid),
        .o_pix_ready   (pix_ready),
        .i_pix         (pix),
        .i_ram_rdata   (ram_rdata),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_color (o_pixel_color),
        .o_column      (o_column),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ----- rtl/bmpc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bmpc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bmpc_expand.sv -----
// Item register, byte assembly and pixel sequencer of the classifier.
// Depends on bmpc_pkg; drives the palette RAM ports and the result stage.
module bmpc_expand
    import bmpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_operation,
    input  logic [7:0]        i_data_byte,
    input  logic              i_row_start,
    input  logic [7:0]        i_palette_index,
    input  logic [7:0]        i_palette_red,
    input  logic [7:0]        i_palette_green,
    input  logic [7:0]        i_palette_blue,
    output logic              o_pix_valid,
    input  logic              i_pix_ready,
    output t_pix              o_pix,
    output logic              o_ram_we,
    output logic [PAL_AW-1:0] o_ram_waddr,
    output logic [1:0]        o_ram_wdata,
    output logic              o_ram_re,
    output logic [PAL_AW-1:0] o_ram_raddr
);

    logic             r_vld;
    logic             r_op;
    logic [7:0]       r_byte;
    logic             r_rs;
    logic [7:0]       r_pidx;
    logic [7:0]       r_pr;
    logic [7:0]       r_pg;
    logic [7:0]       r_pb;
    logic [2:0]       r_sub;
    logic [COL_W-1:0] r_col;
    logic [15:0]      r_hb;
    logic [1:0]       r_hc;

    logic [COL_W-1:0] n_col;
    logic [15:0]      n_hb;
    logic [1:0]       n_hc;

    logic             clr;
    logic [COL_W-1:0] col_eff;
    logic [15:0]      hb_eff;
    logic [1:0]       hc_eff;
    logic [COL_W-1:0] lim;
    logic             col_on;
    logic             emit;
    logic             done;
    logic             last_sub;
    logic [7:0]       pn;
    logic [7:0]       cr;
    logic [7:0]       cg;
    logic [7:0]       cb;
    logic             fires;
    logic             accept;

    assign clr     = r_rs && (r_op == OP_PIXEL);
    assign col_eff = clr ? '0 : r_col;
    assign hb_eff  = clr ? '0 : r_hb;
    assign hc_eff  = clr ? HELD_NONE : r_hc;
    assign col_on  = i_cfg.color_en && (i_cfg.depth != DEPTH_1);
    assign lim     = (int'(i_cfg.row_pixels) > MAX_ROW_PIXELS) ? COL_W'(MAX_ROW_PIXELS)
                                                               : COL_W'(i_cfg.row_pixels);

    always_comb begin
        unique case (i_cfg.depth)
            DEPTH_1: begin
                pn       = {7'd0, r_byte[3'd7 - r_sub]};
                last_sub = (r_sub == 3'd7);
            end
            DEPTH_4: begin
                pn       = r_sub[0] ? {4'd0, r_byte[3:0]} : {4'd0, r_byte[7:4]};
                last_sub = r_sub[0];
            end
            default: begin
                pn       = r_byte;
                last_sub = 1'b1;
            end
        endcase
    end

    always_comb begin
        cb = hb_eff[7:0];
        cg = hb_eff[15:8];
        cr = r_byte;
        if (i_cfg.depth == DEPTH_16) begin
            cb = {hb_eff[4:0], 3'b000};
            if (i_cfg.green_six) begin
                cg = {r_byte[2:0], hb_eff[7:5], 2'b00};
                cr = {r_byte[7:3], 3'b000};
            end else begin
                cg = {r_byte[1:0], hb_eff[7:5], 3'b000};
                cr = {r_byte[6:2], 3'b000};
            end
        end
    end

    always_comb begin
        emit         = 1'b0;
        done         = 1'b1;
        n_col        = col_eff;
        n_hb         = hb_eff;
        n_hc         = hc_eff;
        o_ram_we     = 1'b0;
        o_pix.pal    = 1'b0;
        o_pix.pn_ok  = ({1'b0, pn} < 9'(PALETTE_ENTRIES));
        o_pix.col_on = col_on;
        o_pix.color  = f_pick(f_whitish(cr, cg, cb, col_on), f_colored(cr, cg, cb), col_on);
        o_pix.column = OUT_COL_W'(col_eff);
        o_pix.last   = 1'b1;
        if (r_op == OP_PALETTE) begin
            o_ram_we = r_vld && ({1'b0, r_pidx} < 9'(PALETTE_ENTRIES));
        end else if (col_eff < lim) begin
            unique case (i_cfg.depth)
                DEPTH_24: begin
                    unique case (hc_eff)
                        HELD_NONE: begin
                            n_hb = {8'd0, r_byte};
                            n_hc = HELD_ONE;
                        end
                        HELD_ONE: begin
                            n_hb = {r_byte, hb_eff[7:0]};
                            n_hc = HELD_TWO;
                        end
                        default: begin
                            emit  = 1'b1;
                            n_hb  = '0;
                            n_hc  = HELD_NONE;
                            n_col = col_eff + COL_W'(1);
                        end
                    endcase
                end
                DEPTH_16: begin
                    if (hc_eff == HELD_NONE) begin
                        n_hb = {8'd0, r_byte};
                        n_hc = HELD_ONE;
                    end else begin
                        emit  = 1'b1;
                        n_hb  = '0;
                        n_hc  = HELD_NONE;
                        n_col = col_eff + COL_W'(1);
                    end
                end
                DEPTH_1, DEPTH_4, DEPTH_8: begin
                    emit       = 1'b1;
                    o_pix.pal  = 1'b1;
                    n_col      = col_eff + COL_W'(1);
                    done       = last_sub || (n_col >= lim);
                    o_pix.last = done;
                end
                default: begin
                end
            endcase
        end
    end

    assign fires       = r_vld && (!emit || i_pix_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_in_ready  = !r_vld || (fires && done);
    assign o_pix_valid = r_vld && emit;
    assign o_ram_re    = fires && emit && o_pix.pal;
    assign o_ram_raddr = PAL_AW'(pn);
    assign o_ram_waddr = PAL_AW'(r_pidx);
    assign o_ram_wdata = {f_whitish(r_pr, r_pg, r_pb, col_on), f_colored(r_pr, r_pg, r_pb)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_rs  <= 1'b0;
            r_sub <= '0;
            r_col <= '0;
            r_hb  <= '0;
            r_hc  <= HELD_NONE;
        end else begin
            if (fires) begin
                r_col <= n_col;
                r_hb  <= n_hb;
                r_hc  <= n_hc;
            end
            if (accept) begin
                r_vld  <= 1'b1;
                r_sub  <= '0;
                r_rs   <= i_row_start;
                r_op   <= i_operation;
                r_byte <= i_data_byte;
                r_pidx <= i_palette_index;
                r_pr   <= i_palette_red;
                r_pg   <= i_palette_green;
                r_pb   <= i_palette_blue;
            end else if (fires) begin
                r_rs  <= 1'b0;
                r_sub <= done ? 3'd0 : r_sub + 3'd1;
                if (done) begin
                    r_vld <= 1'b0;
                end
            end
        end
    end

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_col) <= MAX_ROW_PIXELS)
        else $error("column count beyond row maximum");

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hc != 2'd3)
        else $error("held byte count overflow");

    a_rs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sub != 3'd0) |-> !r_rs)
        else $error("row start pending after first pixel of byte");

    a_pal_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && (r_op == OP_PALETTE)) |-> (!emit && o_in_ready))
        else $error("palette beat stalled or emitted a pixel");

endmodule

// ----- rtl/bmpc_result.sv -----
// Result register of the classifier; resolves palette pixels from RAM data.
// Depends on bmpc_pkg; fed by bmpc_expand and the palette RAM read port.
module bmpc_result
    import bmpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_pix_valid,
    output logic                 o_pix_ready,
    input  t_pix                 i_pix,
    input  logic [1:0]           i_ram_rdata,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_pixel_color,
    output logic [OUT_COL_W-1:0] o_column,
    output logic                 o_last_of_run
);

    logic r_vld;
    t_pix r_pix;

    assign o_pix_ready = !r_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            if (o_pix_ready) begin
                r_vld <= i_pix_valid;
            end
            if (o_pix_ready && i_pix_valid) begin
                r_pix <= i_pix;
            end
        end
    end

    always_comb begin
        if (!r_pix.pal) begin
            o_pixel_color = r_pix.color;
        end else if (r_pix.pn_ok) begin
            o_pixel_color = f_pick(i_ram_rdata[1], i_ram_rdata[0], r_pix.col_on);
        end else begin
            o_pixel_color = COLOR_BLACK;
        end
    end

    assign o_out_valid   = r_vld;
    assign o_column      = r_pix.column;
    assign o_last_of_run = r_pix.last;

endmodule
